@@ hdl/rtv_pkg.sv @@
package rtv_pkg;

    localparam int MAX_REGIONS_DEF = 64;

    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_TOO_MANY = 3'd1;
    localparam logic [2:0] ST_NULL_ID  = 3'd2;
    localparam logic [2:0] ST_BAD_SPAN = 3'd3;
    localparam logic [2:0] ST_OVERLAP  = 3'd4;

    localparam logic [15:0] NO_INDEX = 16'hFFFF;

    localparam logic [0:0] REG_BUFFER_BYTES = 1'd0;
    localparam logic [0:0] REG_NULL_ID      = 1'd1;

    typedef struct packed {
        logic        active;
        logic [15:0] id;
        logic [31:0] offset;
        logic [31:0] length;
    } region_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] failing_index;
        logic [15:0] table_entries;
        logic [6:0]  active_seen;
        logic [6:0]  inactive_seen;
        logic [31:0] bytes_in_use;
    } result_t;

endpackage

@@ hdl/region_table_validator.sv @@
// Timing: m_tvalid rises after the closing transaction once the check ends; each active
// entry that reaches the overlap sweep is compared with the later entries in turn, and an
// empty or overfull table is reported without the sweep.
// Throughput: loading takes one cycle per descriptor; input holds from the closing
// transaction until the result is taken. The overlap sweep over later entries sets the rate.
// Reset: aresetn sync active low; clears counters, buffer_bytes, m_tvalid; null_id to FFFF.
module region_table_validator
    import rtv_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: carries_entry[0], region_active[1], region_id[17:2],
    // region_offset[49:18], region_length[81:50], zero fill
    input  logic [87:0]  s_tdata,
    input  logic         s_tlast,   // last_entry
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], failing_index[18:3], table_entries[34:19],
    // active_seen[41:35], inactive_seen[48:42], bytes_in_use[80:49], zero fill
    output logic [87:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [31:0]   buffer_bytes_reg;
    logic [15:0]   null_id_reg;
    logic [CW-1:0] count_reg;
    logic [15:0]   entries_reg;
    logic          overflow_reg;
    logic          start_reg;
    logic [CW-1:0] start_count_reg;
    logic [15:0]   start_entries_reg;
    logic          start_ovf_reg;
    logic          m_valid_reg;
    result_t       m_data_reg;

    logic          s_fire, closing, busy, done;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    region_t       rd_data_a, rd_data_b, wr_data;
    result_t       result;
    logic [15:0]   entries_inc;
    logic          store_ok;

    assign cfg_ready = 1'b1;
    // hold input while validating, while the result is being captured or while it waits
    assign s_tready  = !busy && !start_reg && !done && !m_valid_reg;
    assign s_fire    = s_tvalid && s_tready;
    assign closing   = s_fire && (!s_tdata[0] || s_tlast);
    assign store_ok  = (count_reg < CW'(MAX_REGIONS));
    assign entries_inc = (entries_reg == 16'hFFFF) ? entries_reg : entries_reg + 16'd1;

    assign wr_data.active = s_tdata[1];
    assign wr_data.id     = s_tdata[17:2];
    assign wr_data.offset = s_tdata[49:18];
    assign wr_data.length = s_tdata[81:50];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_bytes_reg <= '0;
            null_id_reg      <= 16'hFFFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BUFFER_BYTES: buffer_bytes_reg <= cfg_data;
                REG_NULL_ID:      null_id_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // load counters; snapshot them when the table closes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            entries_reg  <= '0;
            overflow_reg <= 1'b0;
            start_reg    <= 1'b0;
        end else begin
            start_reg <= closing;
            if (closing) begin
                count_reg    <= '0;
                entries_reg  <= '0;
                overflow_reg <= 1'b0;
            end else if (s_fire) begin
                if (store_ok) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
                entries_reg <= entries_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (closing) begin
            if (s_tdata[0]) begin
                start_count_reg   <= store_ok ? count_reg + 1'b1 : count_reg;
                start_ovf_reg     <= overflow_reg || !store_ok;
                start_entries_reg <= entries_inc;
            end else begin
                start_count_reg   <= count_reg;
                start_ovf_reg     <= overflow_reg;
                start_entries_reg <= entries_reg;
            end
        end
    end

    rtv_store #(.MAX_REGIONS(MAX_REGIONS), .AW(AW)) u_store (
        .aclk      (aclk),
        .wr_en     (s_fire && s_tdata[0] && store_ok),
        .wr_addr   (count_reg[AW-1:0]),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    rtv_check #(.MAX_REGIONS(MAX_REGIONS), .AW(AW), .CW(CW)) u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start_reg),
        .count        (start_count_reg),
        .overflow     (start_ovf_reg),
        .entries      (start_entries_reg),
        .buffer_bytes (buffer_bytes_reg),
        .null_id      (null_id_reg),
        .rd_addr_a    (rd_addr_a),
        .rd_data_a    (rd_data_a),
        .rd_addr_b    (rd_addr_b),
        .rd_data_b    (rd_data_b),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

    // output register: capture the result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg.bytes_in_use, m_data_reg.inactive_seen,
                       m_data_reg.active_seen, m_data_reg.table_entries,
                       m_data_reg.failing_index, m_data_reg.status};

`ifndef NO_ASSERTIONS
    a_no_input_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("input accepted during validation");
    a_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held");
    a_close_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        closing |=> start_reg) else $error("close did not start check");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_REGIONS)) else $error("count beyond capacity");
`endif

endmodule

@@ hdl/rtv_store.sv @@
module rtv_store
    import rtv_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  region_t       wr_data,
    input  logic [AW-1:0] rd_addr_a,
    output region_t       rd_data_a,
    input  logic [AW-1:0] rd_addr_b,
    output region_t       rd_data_b
);

    region_t mem [MAX_REGIONS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ hdl/rtv_check.sv @@
module rtv_check
    import rtv_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
    parameter int CW = $clog2(MAX_REGIONS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [CW-1:0] count,
    input  logic          overflow,
    input  logic [15:0]   entries,
    input  logic [31:0]   buffer_bytes,
    input  logic [15:0]   null_id,
    output logic [AW-1:0] rd_addr_a,
    input  region_t       rd_data_a,
    output logic [AW-1:0] rd_addr_b,
    input  region_t       rd_data_b,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_OUTER = 2'd1;
    localparam logic [1:0] S_INNER = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          jv_reg, jv_next;
    logic [CW-1:0] jd_reg, jd_next;
    logic [CW-1:0] n_reg, n_next;
    logic [6:0]    act_reg, act_next, inact_reg, inact_next;
    logic [31:0]   bytes_reg, bytes_next;
    logic          done_next;
    result_t       result_next;
    logic [32:0]   end_i, end_j;
    logic          meet;

    assign rd_addr_a = i_next[AW-1:0];
    assign rd_addr_b = j_next[AW-1:0];
    assign busy      = (state_reg != S_IDLE);

    assign end_i = {1'b0, rd_data_a.offset} + {1'b0, rd_data_a.length};
    assign end_j = {1'b0, rd_data_b.offset} + {1'b0, rd_data_b.length};
    assign meet  = ({1'b0, rd_data_a.offset} < end_j) && ({1'b0, rd_data_b.offset} < end_i);

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        jv_next     = 1'b0;
        jd_next     = j_reg;
        n_next      = n_reg;
        act_next    = act_reg;
        inact_next  = inact_reg;
        bytes_next  = bytes_reg;
        done_next   = 1'b0;
        result_next = result;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    act_next   = '0;
                    inact_next = '0;
                    bytes_next = '0;
                    i_next     = '0;
                    n_next     = count;
                    if (overflow || count == '0) begin
                        done_next   = 1'b1;
                        result_next = '{overflow ? ST_TOO_MANY : ST_VALID, NO_INDEX,
                                        entries, 7'd0, 7'd0, 32'd0};
                    end else begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                // entry i is being read
                state_next = S_OUTER;
            end
            S_OUTER: begin
                if (!rd_data_a.active) begin
                    inact_next = inact_reg + 7'd1;
                    i_next     = i_reg + 1'b1;
                    if (i_next == n_reg) begin
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                        result_next = '{ST_VALID, NO_INDEX, entries, act_reg, inact_next,
                                        bytes_reg};
                    end else begin
                        state_next = S_WAIT;
                    end
                end else if (rd_data_a.id == null_id) begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    result_next = '{ST_NULL_ID, 16'(i_reg), entries, act_reg, inact_reg,
                                    bytes_reg};
                end else if (rd_data_a.length == '0 || end_i > {1'b0, buffer_bytes}) begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    result_next = '{ST_BAD_SPAN, 16'(i_reg), entries, act_reg, inact_reg,
                                    bytes_reg};
                end else begin
                    j_next     = i_reg + 1'b1;
                    jv_next    = (j_next != n_reg);
                    jd_next    = j_next;
                    state_next = S_INNER;
                end
            end
            default: begin
                // S_INNER: rd_data_b holds entry jd_reg when jv_reg
                if (jv_reg && rd_data_b.active && meet) begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    result_next = '{ST_OVERLAP, 16'(jd_reg), entries, act_reg, inact_reg,
                                    bytes_reg};
                end else if (!jv_reg) begin
                    act_next   = act_reg + 7'd1;
                    bytes_next = bytes_reg + rd_data_a.length;
                    i_next     = i_reg + 1'b1;
                    if (i_next == n_reg) begin
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                        result_next = '{ST_VALID, NO_INDEX, entries, act_next, inact_reg,
                                        bytes_next};
                    end else begin
                        state_next = S_WAIT;
                    end
                end else begin
                    j_next  = j_reg + 1'b1;
                    jv_next = (j_next != n_reg);
                    jd_next = j_next;
                end
            end
        endcase
    end

    // rd_data_a keeps entry i during the inner sweep since i_next holds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end else begin
            state_reg <= state_next;
            done      <= done_next;
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        jv_reg    <= jv_next;
        jd_reg    <= jd_next;
        n_reg     <= n_next;
        act_reg   <= act_next;
        inact_reg <= inact_next;
        bytes_reg <= bytes_next;
        result    <= result_next;
    end

endmodule
